@@ hdl/swd_pkg.sv @@
// Shared types and constants of the symmetric window derivative block.
`default_nettype none
package swd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DERIV_W    = 21;
	localparam int IDX_W      = 16;
	localparam int STEP_W     = 4;
	localparam int HIST_DEPTH = 32;
	localparam int HIST_AW    = 5;

	localparam logic [STEP_W-1:0] DIFF_STEP_RST = 4'd7;
	localparam logic [IDX_W-1:0]  LAST_INDEX    = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SUM,
		ST_DRAIN,
		ST_LOAD,
		ST_EMIT
	} swd_state_t;

	typedef struct packed {
		logic in_ready;
		logic accept;
		logic start;
		logic issue;
		logic load;
		logic out_valid;
		logic advance;
		logic finish;
	} swd_cmd_t;

	typedef struct packed {
		logic pending;
		logic k_zero;
		logic j_done;
	} swd_status_t;

endpackage
`default_nettype wire

@@ hdl/swd_if.sv @@
// Request channel interfaces for samples in and derivative results out.
`default_nettype none
interface swd_in_if import swd_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface swd_out_if import swd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DERIV_W-1:0] derivative;
	logic [IDX_W-1:0]          sample_index;
	logic                      last_result;

	modport source (output valid, output derivative, output sample_index,
		output last_result, input ready);
	modport sink   (input valid, input derivative, input sample_index,
		input last_result, output ready);
endinterface
`default_nettype wire

@@ hdl/swd_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module swd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

@@ hdl/swd_ctrl.sv @@
// Controller state machine: sequences accept, window summing and result hand-off.
`default_nettype none
module swd_ctrl import swd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        out_ready,
	input  wire swd_status_t sts,
	output swd_cmd_t         cmd
);

	swd_state_t state_q;
	swd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.pending) begin
					cmd.start = 1'b1;
					state_d   = sts.k_zero ? ST_LOAD : ST_SUM;
				end else begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SUM: begin
				cmd.issue = 1'b1;
				if (sts.j_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.out_valid = 1'b1;
				if (out_ready) begin
					cmd.advance = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/swd_dp.sv @@
// Datapath: record counters, sample history, window sums and result register.
`default_nettype none
module swd_dp import swd_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [STEP_W-1:0]          cfg_data,
	input  wire logic signed [SAMPLE_W-1:0] in_sample,
	input  wire logic                       in_last,
	input  wire swd_cmd_t                   cmd,
	output swd_status_t                     sts,
	output logic signed [DERIV_W-1:0]       out_derivative,
	output logic [IDX_W-1:0]                out_index,
	output logic                            out_last
);

	logic [STEP_W-1:0]         step_q;
	logic [IDX_W-1:0]          count_q;
	logic [IDX_W-1:0]          next_q;
	logic [IDX_W-1:0]          cur_q;
	logic                      last_q;
	logic [STEP_W-1:0]         k_q;
	logic [STEP_W-1:0]         j_q;
	logic                      issue_s1;
	logic signed [DERIV_W-1:0] sum_after_q;
	logic signed [DERIV_W-1:0] sum_before_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic [IDX_W-1:0]          index_q;
	logic                      rlast_q;

	logic [IDX_W-1:0]    span;
	logic [STEP_W-1:0]   kmin;
	logic [IDX_W:0]      reach;
	logic [HIST_AW-1:0]  raddr_a;
	logic [HIST_AW-1:0]  raddr_b;
	logic [SAMPLE_W-1:0] rdata_a;
	logic [SAMPLE_W-1:0] rdata_b;

	// Window half width: min of distance to record start, step and distance to end.
	always_comb begin
		span  = cur_q - next_q;
		reach = {1'b0, next_q} + {{(IDX_W + 1 - STEP_W){1'b0}}, step_q};
		kmin  = step_q;
		if (next_q < {{(IDX_W - STEP_W){1'b0}}, kmin}) begin
			kmin = next_q[STEP_W-1:0];
		end
		if (span < {{(IDX_W - STEP_W){1'b0}}, kmin}) begin
			kmin = span[STEP_W-1:0];
		end
		sts.pending = (next_q <= cur_q) && (last_q || (reach <= {1'b0, cur_q}));
		sts.k_zero  = (kmin == '0);
		sts.j_done  = (j_q == k_q);
	end

	assign raddr_a = next_q[HIST_AW-1:0] + {{(HIST_AW - STEP_W){1'b0}}, j_q};
	assign raddr_b = next_q[HIST_AW-1:0] - {{(HIST_AW - STEP_W){1'b0}}, j_q};

	swd_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (HIST_DEPTH)
	) u_hist (
		.clk     (clk),
		.we      (cmd.accept),
		.waddr   (count_q[HIST_AW-1:0]),
		.wdata   (in_sample),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= DIFF_STEP_RST;
			count_q  <= '0;
			next_q   <= '0;
			issue_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				step_q <= cfg_data;
			end
			issue_s1 <= cmd.issue;
			if (cmd.advance) begin
				next_q <= next_q + 1'b1;
			end
			if (cmd.finish) begin
				if (last_q) begin
					count_q <= '0;
					next_q  <= '0;
				end else begin
					count_q <= cur_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q  <= count_q;
			last_q <= in_last || (count_q == LAST_INDEX);
		end
		if (cmd.start) begin
			k_q          <= kmin;
			j_q          <= {{(STEP_W - 1){1'b0}}, 1'b1};
			sum_after_q  <= '0;
			sum_before_q <= '0;
		end else begin
			if (cmd.issue) begin
				j_q <= j_q + 1'b1;
			end
			if (issue_s1) begin
				sum_after_q  <= sum_after_q +
					{{(DERIV_W - SAMPLE_W){rdata_a[SAMPLE_W-1]}}, rdata_a};
				sum_before_q <= sum_before_q +
					{{(DERIV_W - SAMPLE_W){rdata_b[SAMPLE_W-1]}}, rdata_b};
			end
		end
		if (cmd.load) begin
			deriv_q <= sum_after_q - sum_before_q;
			index_q <= next_q;
			rlast_q <= last_q && (next_q == cur_q);
		end
	end

	assign out_derivative = deriv_q;
	assign out_index      = index_q;
	assign out_last       = rlast_q;

endmodule
`default_nettype wire

@@ hdl/symmetric_window_derivative.sv @@
// Top level of the symmetric boxcar difference derivative filter.
// Flow: an item that releases no result passes only through accept and check.
// Each released result then passes check, the window sums (skipped when k is 0), drain,
// load and emit, k being its window half width: the window sums are built one sample
// pair per cycle from a two-read history RAM, and the result is valid in emit.
// Reset (arst_n low, asynchronous): record counters clear, diff_step returns to 7.
`default_nettype none
module symmetric_window_derivative import swd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [STEP_W-1:0] cfg_data,
	swd_in_if.sink                 in_ch,
	swd_out_if.source              out_ch
);

	swd_cmd_t    cmd;
	swd_status_t sts;

	// Controller: takes one request at a time, then walks every index whose
	// window is complete, and hands each result off before checking the next.
	swd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: history ring indexed by the low index bits, pairwise window
	// accumulation (after and before), and the registered result.
	swd_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_sample      (in_ch.sample),
		.in_last        (in_ch.last_sample),
		.cmd            (cmd),
		.sts            (sts),
		.out_derivative (out_ch.derivative),
		.out_index      (out_ch.sample_index),
		.out_last       (out_ch.last_result)
	);

	// Hold ready only while idle; hold valid until the result request is taken.
	assign in_ch.ready  = cmd.in_ready;
	assign out_ch.valid = cmd.out_valid;

endmodule
`default_nettype wire

@@ bench/swd_deriv_check.sv @@
// Scoreboard that predicts and checks derivative results of the window derivative block.
`timescale 1ns / 1ps
module swd_deriv_check import swd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [STEP_W-1:0] cfg_data,
	swd_in_if                 in_ch,
	swd_out_if                out_ch,
	output int                fail_count,
	output int                awaited_n
);

	localparam int RECORD_MAX = 65536;
	localparam int BURST_CAP  = 17;
	localparam int STEP_MAX   = 15;

	typedef struct {
		logic signed [DERIV_W-1:0] derivative;
		logic [IDX_W-1:0]          sample_index;
		logic                      last_result;
	} deriv_item_t;

	logic [SAMPLE_W-1:0] ring [HIST_DEPTH];
	logic [STEP_W-1:0]   half_w;
	int                  rec_count;
	int                  next_idx;
	int                  mismatches;
	deriv_item_t         awaited_derivs[$];

	// Store one sample and queue every derivative whose windows are now known.
	function automatic void predict_derivatives(input logic [SAMPLE_W-1:0] s,
		input logic lst);
		int          cur;
		int          idx;
		int          k;
		int          j;
		int          after_sum;
		int          before_sum;
		int          produced;
		logic        closes;
		deriv_item_t d;
		cur = rec_count;
		closes = lst || (cur >= RECORD_MAX - 1);
		ring[cur % HIST_DEPTH] = s;
		produced = 0;
		while (produced < BURST_CAP && next_idx <= cur &&
			(closes || next_idx + int'(half_w) <= cur)) begin
			idx = next_idx;
			k = int'(half_w);
			if (idx < k) k = idx;
			if (cur - idx < k) k = cur - idx;
			if (k > STEP_MAX) k = STEP_MAX;
			after_sum = 0;
			before_sum = 0;
			for (j = 1; j <= k; j++) begin
				after_sum  += int'($signed(ring[(idx + j) % HIST_DEPTH]));
				before_sum += int'($signed(ring[(idx - j) % HIST_DEPTH]));
			end
			d.derivative   = DERIV_W'(after_sum - before_sum);
			d.sample_index = IDX_W'(idx);
			d.last_result  = closes && (idx == cur);
			awaited_derivs.insert(awaited_derivs.size(), d);
			produced++;
			next_idx++;
		end
		if (closes) begin
			rec_count = 0;
			next_idx = 0;
		end else begin
			rec_count = cur + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		deriv_item_t want;
		if (!arst_n) begin
			half_w = DIFF_STEP_RST;
			rec_count = 0;
			next_idx = 0;
			mismatches = 0;
			awaited_derivs.delete();
			fail_count <= 0;
			awaited_n <= 0;
		end else begin
			// Compare first: a result never belongs to a request taken at the same edge.
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_derivs.size() == 0) begin
					$error("unexpected result: derivative %0d sample_index %0d last_result %0b",
						out_ch.derivative, out_ch.sample_index, out_ch.last_result);
					mismatches++;
				end else begin
					want = awaited_derivs.pop_front();
					if (out_ch.derivative !== want.derivative) begin
						$error("derivative: expected %0d, actual %0d",
							want.derivative, out_ch.derivative);
						mismatches++;
					end
					if (out_ch.sample_index !== want.sample_index) begin
						$error("sample_index: expected %0d, actual %0d",
							want.sample_index, out_ch.sample_index);
						mismatches++;
					end
					if (out_ch.last_result !== want.last_result) begin
						$error("last_result: expected %0b, actual %0b",
							want.last_result, out_ch.last_result);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				half_w = cfg_data;
			if (in_ch.valid && in_ch.ready)
				predict_derivatives(in_ch.sample, in_ch.last_sample);
			fail_count <= mismatches;
			awaited_n <= awaited_derivs.size();
		end
	end

endmodule

@@ bench/symmetric_window_derivative_tb.sv @@
// Stimulus and verdict for the symmetric window derivative block.
`timescale 1ns / 1ps
module symmetric_window_derivative_tb import swd_pkg::*; ();

	localparam int RAND_ITEMS = 480;
	localparam int LONG_HOLD  = 300;
	// Margin for the longest result, whose window half width k is up to 15; leave ample margin.
	localparam int SETTLE     = 40;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [STEP_W-1:0] cfg_data;
	int                fail_count;
	int                awaited_n;

	// Shared knobs between the stimulus and the result-side process.
	logic calm;
	logic hold_ask;

	logic [SAMPLE_W-1:0] record_buf[$];

	swd_in_if  in_ch ();
	swd_out_if out_ch ();

	symmetric_window_derivative dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	swd_deriv_check scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.fail_count(fail_count),
		.awaited_n (awaited_n)
	);

	always #6 clk = ~clk;

	// Result side: drive ready once per edge. A hold request keeps ready low for
	// a long stretch so the block backs up and stalls the sample requests.
	initial begin : result_side
		int hold_left;
		hold_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_ask) begin
				hold_ask = 1'b0;
				hold_left = LONG_HOLD - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= calm || ($urandom_range(99) >= 16);
			end
		end
	end

	// Offer one sample request, idling at random first; return at the edge that
	// takes it. Valid gets exactly one assignment per step, so back to back
	// requests keep it high.
	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic lst);
		while (!calm && $urandom_range(99) < 16) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.sample      <= s;
		in_ch.last_sample <= lst;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// Send the buffered samples as one closed record.
	task automatic send_buffer();
		foreach (record_buf[j])
			send_sample(record_buf[j], j == record_buf.size() - 1);
	endtask

	// Send a record of random samples, or a step shape that drives the window
	// sums to their extremes; close it only when asked.
	task automatic send_record(input int len, input logic close, input logic stepped);
		logic [SAMPLE_W-1:0] v;
		for (int j = 0; j < len; j++) begin
			if (stepped) begin
				v = (j < len / 2) ? 16'h8000 : 16'h7FFF;
			end else begin
				case ($urandom_range(9))
					0: v = 16'h8000;
					1: v = 16'h7FFF;
					2: v = '0;
					3, 4, 5: v = SAMPLE_W'(int'($urandom_range(400)) - 200);
					default: v = SAMPLE_W'($urandom);
				endcase
			end
			send_sample(v, close && (j == len - 1));
		end
	endtask

	// Drop valid, wait until every expected result has arrived, then let the
	// block finish any item that released nothing.
	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (awaited_n != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write the window half width; only ever called with the block idle.
	task automatic write_step(input logic [STEP_W-1:0] v);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin : stimulus
		int                phase;
		int                phase_items;
		int                n;
		int                len;
		int                sent_rand;
		logic              stepped;
		logic              open_tail;
		logic              paused;
		logic [STEP_W-1:0] step;

		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_data          <= DIFF_STEP_RST;
		in_ch.valid       <= 1'b0;
		in_ch.sample      <= '0;
		in_ch.last_sample <= 1'b0;
		calm     = 1'b0;
		hold_ask = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset step of 7 with records too short to fill a window,
		// including a single-sample record whose only result is both first and last.
		record_buf = {16'h8000};
		send_buffer();
		record_buf = {16'h7FFF, 16'h8000};
		send_buffer();
		record_buf = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
		send_buffer();
		wait_drain();

		// Zero step: every index comes out on its own sample with derivative 0.
		write_step(4'd0);
		record_buf = {16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA};
		send_buffer();
		wait_drain();

		write_step(4'd1);
		record_buf = {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001};
		send_buffer();
		wait_drain();

		// Widest step on a record shorter than the window: the tail carries it all.
		write_step(4'd15);
		record_buf = {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000};
		send_buffer();
		wait_drain();

		// Random phases, each under its own step. Visit the extremes first; hold
		// off the result side in one phase, run without idling in another, pause
		// the sender mid-phase in a third, and leave some records open so the step
		// changes within a record.
		sent_rand = 0;
		phase = 0;
		while (sent_rand < RAND_ITEMS) begin
			case (phase)
				0: step = 4'd15;
				1: step = 4'd1;
				2: step = 4'd0;
				default: step = STEP_W'($urandom_range(15));
			endcase
			write_step(step);
			calm = (phase == 3);
			if (phase == 1)
				hold_ask = 1'b1;
			open_tail = (phase % 3 == 2);
			paused = 1'b0;
			phase_items = $urandom_range(35, 60);
			n = 0;
			while (n < phase_items) begin
				stepped = ($urandom_range(7) == 0);
				if (stepped)
					len = $urandom_range(31, 40);
				else if ($urandom_range(3) == 0)
					len = $urandom_range(1, 3);
				else
					len = $urandom_range(4, 30);
				send_record(len, !(open_tail && n + len >= phase_items), stepped);
				n += len;
				if (phase == 4 && !paused && n >= phase_items / 2) begin
					wait_drain();
					paused = 1'b1;
				end
			end
			sent_rand += n;
			wait_drain();
			phase++;
		end
		calm = 1'b0;

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin : watchdog
		#60_000_000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/swd_pkg.sv
hdl/swd_if.sv
hdl/swd_ram.sv
hdl/swd_ctrl.sv
hdl/swd_dp.sv
hdl/symmetric_window_derivative.sv
bench/swd_deriv_check.sv
bench/symmetric_window_derivative_tb.sv
